[design/e2r_pkg.sv]
// Shared constants and the CORDIC arctangent table for the Euler-to-DCM block.
`timescale 1ns / 1ps
package e2r_pkg;

  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 16;
  localparam int TURN_W  = 32;
  localparam int ATAN_N  = 24;

  // round(0.6072529350088813 * 2^30)
  localparam logic signed [TURN_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TURN_W-1:0] atan_turn32(input logic [4:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/e2r_cordic_lane.sv]
// One sine/cosine lane: quadrant fold, pipelined CORDIC, rounding and quadrant map.
`timescale 1ns / 1ps
module e2r_cordic_lane #(
  parameter int ANGLE_BITS   = 16,
  parameter int FRAC_BITS    = 15,
  parameter int CORDIC_STEPS = 16,
  localparam int SCW  = FRAC_BITS + 2,
  localparam int NSTG = CORDIC_STEPS + 2
) (
  input  logic                              clk_i,
  input  logic [e2r_pkg::ANGLE_W-1:0]       angle_i,
  input  logic [NSTG-1:0]                   en_i,
  output logic signed [SCW-1:0]             sin_o,
  output logic signed [SCW-1:0]             cos_o
);
  import e2r_pkg::*;

  localparam logic [TURN_W-1:0] KEEP =
    ~((TURN_W'(1) << (TURN_W - ANGLE_BITS)) - TURN_W'(1));
  localparam logic [TURN_W-1:0] EIGHTH = TURN_W'(1) << (TURN_W - 3);
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [TURN_W:0] ONE_W = (TURN_W + 1)'(1) << FRAC_BITS;

  logic [TURN_W-1:0] a, a_bias, resid;
  logic [1:0]        quad;

  logic signed [TURN_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [TURN_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [TURN_W-1:0] z_q [CORDIC_STEPS+1];
  logic [1:0]               q_q [CORDIC_STEPS+1];

  logic signed [TURN_W:0]   xr, yr;
  logic signed [SCW-1:0]    s_c, c_c;
  logic signed [SCW-1:0]    sin_q, cos_q;

  // fold to within an eighth turn of the nearest axis
  assign a      = {angle_i, {(TURN_W - ANGLE_W){1'b0}}} & KEEP;
  assign a_bias = a + EIGHTH;
  assign quad   = a_bias[TURN_W-1 -: 2];
  assign resid  = a - {quad, {(TURN_W - 2){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0] <= CORDIC_GAIN_Q30;
      y_q[0] <= '0;
      z_q[0] <= signed'(resid);
      q_q[0] <= quad;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [TURN_W-1:0] dx, dy, at;
    assign dx = y_q[g] >>> g;
    assign dy = x_q[g] >>> g;
    assign at = signed'(atan_turn32(5'(g)));

    always_ff @(posedge clk_i) begin
      if (en_i[g+1]) begin
        if (!z_q[g][TURN_W-1]) begin
          x_q[g+1] <= x_q[g] - dx;
          y_q[g+1] <= y_q[g] + dy;
          z_q[g+1] <= z_q[g] - at;
        end else begin
          x_q[g+1] <= x_q[g] + dx;
          y_q[g+1] <= y_q[g] - dy;
          z_q[g+1] <= z_q[g] + at;
        end
        q_q[g+1] <= q_q[g];
      end
    end
  end

  // round Q2.30 down to FRAC_BITS fraction bits, add half then floor
  if (SH == 0) begin : g_nornd
    assign xr = (TURN_W + 1)'(x_q[CORDIC_STEPS]);
    assign yr = (TURN_W + 1)'(y_q[CORDIC_STEPS]);
  end else begin : g_rnd
    localparam logic signed [TURN_W:0] HALF = (TURN_W + 1)'(1) << (SH - 1);
    assign xr = ((TURN_W + 1)'(x_q[CORDIC_STEPS]) + HALF) >>> SH;
    assign yr = ((TURN_W + 1)'(y_q[CORDIC_STEPS]) + HALF) >>> SH;
  end

  assign s_c = (yr > ONE_W) ? SCW'(ONE_W) : (yr < -ONE_W) ? SCW'(-ONE_W) : SCW'(yr);
  assign c_c = (xr > ONE_W) ? SCW'(ONE_W) : (xr < -ONE_W) ? SCW'(-ONE_W) : SCW'(xr);

  always_ff @(posedge clk_i) begin
    if (en_i[NSTG-1]) begin
      unique case (q_q[CORDIC_STEPS])
        QUAD_0: begin
          sin_q <= s_c;
          cos_q <= c_c;
        end
        QUAD_1: begin
          sin_q <= c_c;
          cos_q <= -s_c;
        end
        QUAD_2: begin
          sin_q <= -s_c;
          cos_q <= -c_c;
        end
        default: begin
          sin_q <= -c_c;
          cos_q <= s_c;
        end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

[design/e2r_merge.sv]
// Merge stages: products of the three lanes' sine/cosine, sums, rounding, saturation.
`timescale 1ns / 1ps
module e2r_merge #(
  parameter int FRAC_BITS = 15,
  localparam int SCW = FRAC_BITS + 2
) (
  input  logic                          clk_i,
  input  logic [2:0]                    en_i,
  input  logic signed [SCW-1:0]         sx_i,
  input  logic signed [SCW-1:0]         cx_i,
  input  logic signed [SCW-1:0]         sy_i,
  input  logic signed [SCW-1:0]         cy_i,
  input  logic signed [SCW-1:0]         sz_i,
  input  logic signed [SCW-1:0]         cz_i,
  output logic [e2r_pkg::OUT_W-1:0]     r11_o,
  output logic [e2r_pkg::OUT_W-1:0]     r12_o,
  output logic [e2r_pkg::OUT_W-1:0]     r13_o,
  output logic [e2r_pkg::OUT_W-1:0]     r21_o,
  output logic [e2r_pkg::OUT_W-1:0]     r22_o,
  output logic [e2r_pkg::OUT_W-1:0]     r23_o,
  output logic [e2r_pkg::OUT_W-1:0]     r31_o,
  output logic [e2r_pkg::OUT_W-1:0]     r32_o,
  output logic [e2r_pkg::OUT_W-1:0]     r33_o
);
  import e2r_pkg::*;

  localparam int PW  = 2 * SCW;
  localparam int SW  = PW + 1;
  localparam int SHQ = 2 * FRAC_BITS - 15;
  localparam logic signed [SW-1:0] HALF_F = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HALF_Q = SW'(1) << (SHQ - 1);
  localparam logic signed [SW-1:0] QMAX   = SW'(32767);
  localparam logic signed [SW-1:0] QMIN   = -SW'(32768);

  function automatic logic [OUT_W-1:0] to_q15(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + HALF_Q) >>> SHQ;
    if (r > QMAX) r = QMAX;
    if (r < QMIN) r = QMIN;
    return OUT_W'(r);
  endfunction

  // stage 1: pair products
  logic signed [PW-1:0]  czcy_q, szcx_q, szsx_q, szcy_q, czcx_q, czsx_q, cysx_q, cycx_q;
  logic signed [PW-1:0]  sysx_q, sycx_q;
  logic signed [SCW-1:0] cz1_q, sz1_q, sy1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      czcy_q <= PW'(cz_i) * PW'(cy_i);
      szcx_q <= PW'(sz_i) * PW'(cx_i);
      szsx_q <= PW'(sz_i) * PW'(sx_i);
      szcy_q <= PW'(sz_i) * PW'(cy_i);
      czcx_q <= PW'(cz_i) * PW'(cx_i);
      czsx_q <= PW'(cz_i) * PW'(sx_i);
      cysx_q <= PW'(cy_i) * PW'(sx_i);
      cycx_q <= PW'(cy_i) * PW'(cx_i);
      sysx_q <= PW'(sy_i) * PW'(sx_i);
      sycx_q <= PW'(sy_i) * PW'(cx_i);
      cz1_q  <= cz_i;
      sz1_q  <= sz_i;
      sy1_q  <= sy_i;
    end
  end

  // stage 2: round sy*sx, sy*cx back to FRAC_BITS, then the triple products
  logic signed [SCW-1:0] sysx_r, sycx_r;
  logic signed [PW-1:0]  czsysx_q, czsycx_q, szsysx_q, szsycx_q;
  logic signed [PW-1:0]  czcy2_q, szcx2_q, szsx2_q, szcy2_q, czcx2_q, czsx2_q, cysx2_q, cycx2_q;
  logic signed [SCW-1:0] sy2_q;

  assign sysx_r = SCW'((SW'(sysx_q) + HALF_F) >>> FRAC_BITS);
  assign sycx_r = SCW'((SW'(sycx_q) + HALF_F) >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      czsysx_q <= PW'(cz1_q) * PW'(sysx_r);
      czsycx_q <= PW'(cz1_q) * PW'(sycx_r);
      szsysx_q <= PW'(sz1_q) * PW'(sysx_r);
      szsycx_q <= PW'(sz1_q) * PW'(sycx_r);
      czcy2_q  <= czcy_q;
      szcx2_q  <= szcx_q;
      szsx2_q  <= szsx_q;
      szcy2_q  <= szcy_q;
      czcx2_q  <= czcx_q;
      czsx2_q  <= czsx_q;
      cysx2_q  <= cysx_q;
      cycx2_q  <= cycx_q;
      sy2_q    <= sy1_q;
    end
  end

  // stage 3: sums, output rounding and saturation
  logic [OUT_W-1:0] r11_q, r12_q, r13_q, r21_q, r22_q, r23_q, r31_q, r32_q, r33_q;
  logic signed [SW-1:0] nsy_w;

  assign nsy_w = (-SW'(sy2_q)) <<< FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      r11_q <= to_q15(SW'(czcy2_q));
      r12_q <= to_q15(SW'(czsysx_q) - SW'(szcx2_q));
      r13_q <= to_q15(SW'(szsx2_q) + SW'(czsycx_q));
      r21_q <= to_q15(SW'(szcy2_q));
      r22_q <= to_q15(SW'(czcx2_q) + SW'(szsysx_q));
      r23_q <= to_q15(SW'(szsycx_q) - SW'(czsx2_q));
      r31_q <= to_q15(nsy_w);
      r32_q <= to_q15(SW'(cysx2_q));
      r33_q <= to_q15(SW'(cycx2_q));
    end
  end

  assign r11_o = r11_q;
  assign r12_o = r12_q;
  assign r13_o = r13_q;
  assign r21_o = r21_q;
  assign r22_o = r22_q;
  assign r23_o = r23_q;
  assign r31_o = r31_q;
  assign r32_o = r32_q;
  assign r33_o = r33_q;

endmodule

[design/euler_to_rotation_matrix_top.sv]
// Top level: ZYX Euler angles to rotation matrix, three CORDIC lanes and a merge pipeline.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one beat of three signed binary
//   angles (65536 per turn). Output channel (out_valid_o/out_ready_i) carries one
//   beat of the nine entries of R = Rz*Ry*Rx, row-major, signed Q1.15, saturated.
//   A beat accepted passes through the fold stage, the CORDIC stages, the quadrant-map
//   stage and the three merge stages before it shows on the output.
//   Throughput: one beat per cycle when the receiver does not stall. Each of the
//   three lanes is a fully pipelined CORDIC, one stage per iteration, plus fold and
//   quadrant-map stages; the merge side is three stages of multipliers and adders.
//   Every stage has its own valid bit and loads when it is empty or its
//   successor loads, so bubbles collapse and inputs keep flowing while a
//   finished result waits. in_ready_o drops only when every stage is full and
//   the receiver is stalling.
//   Reset clears all valid bits; the data registers are not reset.
module euler_to_rotation_matrix_top #(
  parameter int ANGLE_BITS   = 16,
  parameter int FRAC_BITS    = 15,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [e2r_pkg::ANGLE_W-1:0]   angle_x_i,
  input  logic [e2r_pkg::ANGLE_W-1:0]   angle_y_i,
  input  logic [e2r_pkg::ANGLE_W-1:0]   angle_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [e2r_pkg::OUT_W-1:0]     r11_o,
  output logic [e2r_pkg::OUT_W-1:0]     r12_o,
  output logic [e2r_pkg::OUT_W-1:0]     r13_o,
  output logic [e2r_pkg::OUT_W-1:0]     r21_o,
  output logic [e2r_pkg::OUT_W-1:0]     r22_o,
  output logic [e2r_pkg::OUT_W-1:0]     r23_o,
  output logic [e2r_pkg::OUT_W-1:0]     r31_o,
  output logic [e2r_pkg::OUT_W-1:0]     r32_o,
  output logic [e2r_pkg::OUT_W-1:0]     r33_o
);
  import e2r_pkg::*;

  localparam int SCW = FRAC_BITS + 2;
  localparam int L   = CORDIC_STEPS + 2;
  localparam int N   = L + 3;

  logic [N-1:0] en;
  logic [N-1:0] v_d, v_q;

  logic signed [SCW-1:0] sx, cx, sy, cy, sz, cz;

  // stage loads when empty or when its successor loads
  always_comb begin
    en[N-1] = !v_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < N; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[N-1];

  e2r_cordic_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lane_x (
    .clk_i  (clk_i),
    .angle_i(angle_x_i),
    .en_i   (en[L-1:0]),
    .sin_o  (sx),
    .cos_o  (cx)
  );

  e2r_cordic_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lane_y (
    .clk_i  (clk_i),
    .angle_i(angle_y_i),
    .en_i   (en[L-1:0]),
    .sin_o  (sy),
    .cos_o  (cy)
  );

  e2r_cordic_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_lane_z (
    .clk_i  (clk_i),
    .angle_i(angle_z_i),
    .en_i   (en[L-1:0]),
    .sin_o  (sz),
    .cos_o  (cz)
  );

  e2r_merge #(
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk_i(clk_i),
    .en_i (en[N-1:L]),
    .sx_i (sx),
    .cx_i (cx),
    .sy_i (sy),
    .cy_i (cy),
    .sz_i (sz),
    .cz_i (cz),
    .r11_o(r11_o),
    .r12_o(r12_o),
    .r13_o(r13_o),
    .r21_o(r21_o),
    .r22_o(r22_o),
    .r23_o(r23_o),
    .r31_o(r31_o),
    .r32_o(r32_o),
    .r33_o(r33_o)
  );

  // backpressure only when the whole pipe is full and the receiver stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("in_ready_o low with an empty stage");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted beat not captured in first stage");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !v_q[N-2] |=> !out_valid_o)
    else $error("output beat repeated after hand-off");

endmodule

[tb/tb.sv]
// Testbench for the ZYX Euler-angle to rotation-matrix block: directed, random, stall and full-rate tests.
`timescale 1ns / 1ps
module tb;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 15;
  localparam int CORDIC_STEPS = 16;
  localparam int PIPE_LAT     = CORDIC_STEPS + 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;

  localparam longint GAIN_Q30 = 64'sd652032874;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [0:15][31:0] ATAN_TURN = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  typedef logic [8:0][e2r_pkg::OUT_W-1:0] dcm_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [e2r_pkg::ANGLE_W-1:0] angle_x_i;
  logic [e2r_pkg::ANGLE_W-1:0] angle_y_i;
  logic [e2r_pkg::ANGLE_W-1:0] angle_z_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  dcm_t                        dcm_out;

  dcm_t  dcm_q[$];
  string entry_name[9] = '{"r11", "r12", "r13", "r21", "r22", "r23", "r31", "r32", "r33"};
  int    n_errors    = 0;
  int    n_sent      = 0;
  int    n_checked   = 0;
  int    cycle_cnt   = 0;
  int    rx_hold_req = 0;
  bit    tx_steady   = 0;
  bit    rx_steady   = 0;

  euler_to_rotation_matrix_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .angle_x_i   (angle_x_i),
    .angle_y_i   (angle_y_i),
    .angle_z_i   (angle_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .r11_o       (dcm_out[0]),
    .r12_o       (dcm_out[1]),
    .r13_o       (dcm_out[2]),
    .r21_o       (dcm_out[3]),
    .r22_o       (dcm_out[4]),
    .r23_o       (dcm_out[5]),
    .r31_o       (dcm_out[6]),
    .r32_o       (dcm_out[7]),
    .r33_o       (dcm_out[8])
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint round_down_shift(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_one(input longint v);
    longint one;
    one = 64'sd1 <<< FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic logic [15:0] sat_q15(input longint v);
    longint r;
    r = round_down_shift(v, 2 * FRAC_BITS - 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // CORDIC on the angle folded to its nearest axis, then unfolded by quadrant
  function automatic void angle_sin_cos(input logic [15:0] ang, output longint s_o,
                                        output longint c_o);
    logic [31:0] turn;
    logic [31:0] resid;
    logic [1:0]  quad;
    longint      z, x, y, dx, dy, s, c;
    turn  = {ang, 16'h0000} & ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
    quad  = 2'((turn + 32'h2000_0000) >> 30);
    resid = turn - {quad, 30'h0};
    z     = longint'($signed(resid));
    x     = GAIN_Q30;
    y     = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURN[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURN[i]);
      end
    end
    s = clamp_one(round_down_shift(y, 30 - FRAC_BITS));
    c = clamp_one(round_down_shift(x, 30 - FRAC_BITS));
    case (quad)
      e2r_pkg::QUAD_0: begin s_o = s;  c_o = c;  end
      e2r_pkg::QUAD_1: begin s_o = c;  c_o = -s; end
      e2r_pkg::QUAD_2: begin s_o = -s; c_o = -c; end
      default:         begin s_o = -c; c_o = s;  end
    endcase
  endfunction

  function automatic dcm_t predict_dcm(input logic [15:0] ax, input logic [15:0] ay,
                                       input logic [15:0] az);
    longint sx, cx, sy, cy, sz, cz, sysx, sycx;
    dcm_t   m;
    angle_sin_cos(ax, sx, cx);
    angle_sin_cos(ay, sy, cy);
    angle_sin_cos(az, sz, cz);
    sysx = round_down_shift(sy * sx, FRAC_BITS);
    sycx = round_down_shift(sy * cx, FRAC_BITS);
    m[0] = sat_q15(cz * cy);
    m[1] = sat_q15(-(sz * cx) + cz * sysx);
    m[2] = sat_q15(sz * sx + cz * sycx);
    m[3] = sat_q15(sz * cy);
    m[4] = sat_q15(cz * cx + sz * sysx);
    m[5] = sat_q15(-(cz * sx) + sz * sycx);
    m[6] = sat_q15(-sy * (64'sd1 <<< FRAC_BITS));
    m[7] = sat_q15(cy * sx);
    m[8] = sat_q15(cy * cx);
    return m;
  endfunction

  // ---------------------------------------------------------------- monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      dcm_q.push_back(predict_dcm(angle_x_i, angle_y_i, angle_z_i));
      n_sent++;
    end
  end

  always @(posedge clk_i) begin
    dcm_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dcm_q.size() == 0) begin
        $display("%0t: unexpected matrix beat, nothing pending", $time);
        n_errors++;
      end else begin
        want = dcm_q.pop_front();
        n_checked++;
        for (int k = 0; k < 9; k++) begin
          if (dcm_out[k] !== want[k]) begin
            $display("%0t: %s expected %0d got %0d", $time, entry_name[k],
                     $signed(want[k]), $signed(dcm_out[k]));
            n_errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_req) @(posedge clk_i);
        rx_hold_req = 0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_x_i  <= ax;
    angle_y_i  <= ay;
    angle_z_i  <= az;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom);
      // near an axis or an octant boundary, where folding switches quadrant
      2:       return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 8) - 4);
      default: return 16'($urandom_range(0, 128) - 64);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    logic [15:0] axis [10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                               16'h1FFF, 16'hE000, 16'hDFFF, 16'h7FFF, 16'h0001};
    // identity, exact +1 on the diagonal saturates
    send_angles(16'h0000, 16'h0000, 16'h0000);
    // half turn and the signed extremes
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_angles(16'hFFFF, 16'h8001, 16'h0001);
    // every lane through the quadrant axes and octant boundaries, lanes offset in the list
    for (int i = 0; i < 10; i++)
      send_angles(axis[i], axis[(i + 3) % 10], axis[(i + 7) % 10]);
    // gimbal lock: pitch at plus and minus a quarter turn
    send_angles(16'h1234, 16'h4000, 16'hA5A5);
    send_angles(16'hEDCB, 16'hC000, 16'h5A5A);
    send_angles(16'h6000, 16'h4000, 16'h6000);
    send_angles(16'h2000, 16'h2000, 16'h2000);
    send_angles(16'hE000, 16'hA000, 16'h6000);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    tx_steady = 0;
    rx_steady = 0;
  endtask

  // receiver stops for a long stretch while the sender keeps offering beats
  task automatic test_backpressure();
    rx_hold_req = HOLD_CYCLES;
    tx_steady   = 1;
    for (int n = 0; n < 60; n++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    tx_steady = 0;
  endtask

  task automatic test_full_rate();
    tx_steady = 1;
    rx_steady = 1;
    for (int n = 0; n < 120; n++)
      send_angles(rand_angle(), rand_angle(), rand_angle());
    tx_steady = 0;
    rx_steady = 0;
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    angle_x_i  = '0;
    angle_y_i  = '0;
    angle_z_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(700);
    test_backpressure();
    test_full_rate();
    test_random(550);

    in_valid_i <= 1'b0;
    while (dcm_q.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_LAT) @(posedge clk_i);

    $display("Checked %0d of %0d matrices: axes, octant folds, gimbal lock, random angles,",
             n_checked, n_sent);
    $display("full-rate streaming and a %0d-cycle output stall.", HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
